[rtl/core/vrt_pkg.sv]
// Shared types and codes for the voxel ray traversal unit.
package vrt_pkg;

  // Entry face axis codes.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELTA,
    ST_FIRST,
    ST_WALK
  } vrt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new ray and start the step-size divisions
    logic div_step;   // one quotient bit on every lane
    logic div_end;    // final quotient bit of the current division
    logic phase_first;// current division is the first-crossing one
    logic emit;       // send the current voxel and advance the walk
    logic at_limit;   // this voxel is the last one the step limit allows
  } vrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // the output register can take an item this cycle
    logic walk_last;  // the voxel being sent ends the ray
  } vrt_status_t;

endpackage

[rtl/core/vrt_ctrl.sv]
// Controller state machine: sequences divisions and the voxel walk.
module vrt_ctrl #(
  parameter int FRAC_BITS = 8,
  parameter int MAX_STEPS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vrt_pkg::vrt_status_t status_i,
  output vrt_pkg::vrt_cmd_t    cmd_o
);
  import vrt_pkg::*;

  localparam int QW = FRAC_BITS + 15;
  localparam int BW = $clog2(QW);
  localparam int NW = $clog2(MAX_STEPS + 1);

  vrt_state_e    state_q, state_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [NW-1:0] n_q, n_d;
  logic          bit_end;

  assign bit_end = (bit_q == BW'(QW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DELTA;
      ST_DELTA: if (bit_end) state_d = ST_FIRST;
      ST_FIRST: if (bit_end) state_d = ST_WALK;
      ST_WALK:  if (status_i.out_free && status_i.walk_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    in_stall_o        = 1'b1;
    cmd_o.at_limit    = (n_q == NW'(MAX_STEPS - 1));
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DELTA: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_end  = bit_end;
      end
      ST_FIRST: begin
        cmd_o.div_step    = 1'b1;
        cmd_o.div_end     = bit_end;
        cmd_o.phase_first = 1'b1;
      end
      ST_WALK: cmd_o.emit = status_i.out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    bit_d = bit_q;
    n_d   = n_q;
    if (cmd_o.load) begin
      bit_d = '0;
      n_d   = '0;
    end else if (cmd_o.div_step) begin
      bit_d = bit_end ? '0 : bit_q + 1'b1;
    end else if (cmd_o.emit) begin
      n_d = n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      n_q     <= n_d;
    end
  end

endmodule

[rtl/core/vrt_datapath.sv]
// Datapath: per-axis serial dividers, DDA walk registers and output register.
module vrt_datapath #(
  parameter int FRAC_BITS = 8,
  parameter int CELL_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vrt_pkg::vrt_cmd_t     cmd_i,
  output vrt_pkg::vrt_status_t  status_o,
  input  logic signed [23:0]   origin_x_i,
  input  logic signed [23:0]   origin_y_i,
  input  logic signed [23:0]   origin_z_i,
  input  logic signed [15:0]   dir_x_i,
  input  logic signed [15:0]   dir_y_i,
  input  logic signed [15:0]   dir_z_i,
  input  logic [23:0]          max_distance_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic signed [15:0]   cell_x_o,
  output logic signed [15:0]   cell_y_o,
  output logic signed [15:0]   cell_z_o,
  output logic [1:0]           face_axis_o,
  output logic                 face_negative_o,
  output logic [23:0]          entry_t_o,
  output logic                 truncated_o,
  output logic                 last_o
);
  import vrt_pkg::*;

  localparam int QW = FRAC_BITS + 15;
  localparam int TW = FRAC_BITS + 22;

  logic [CELL_BITS-1:0] cell_q [3];
  logic [FRAC_BITS-1:0] frac_q [3];
  logic                 pos_q  [3];
  logic                 vld_q  [3];
  logic [15:0]          mag_q  [3];
  logic [QW-1:0]        tdel_q [3];
  logic [TW-1:0]        tmax_q [3];
  logic [16:0]          rem_q  [3];
  logic [QW-1:0]        quo_q  [3];
  logic [23:0]          maxd_q;
  logic [TW-1:0]        t_q;
  logic [1:0]           axis_q;
  logic                 neg_q;

  logic signed [23:0]   org   [3];
  logic signed [15:0]   dir   [3];
  logic [16:0]          trial [3];
  logic [16:0]          rem_n [3];
  logic [QW-1:0]        quo_n [3];
  logic [QW-1:0]        num_first [3];

  logic                 out_valid_q;
  logic [15:0]          ocell_q [3];
  logic [1:0]           oaxis_q;
  logic                 oneg_q;
  logic [23:0]          ot_q;
  logic                 otrunc_q;
  logic                 olast_q;

  logic       x_before_y, x_before_z, y_before_z, none_valid;
  logic [1:0] sel;
  logic [TW-1:0] new_t;
  logic       beyond;

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  // One restoring division bit per lane per cycle.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      trial[a] = {rem_q[a][15:0], quo_q[a][QW-1]};
      if (trial[a] >= {1'b0, mag_q[a]}) begin
        rem_n[a] = trial[a] - {1'b0, mag_q[a]};
        quo_n[a] = {quo_q[a][QW-2:0], 1'b1};
      end else begin
        rem_n[a] = trial[a];
        quo_n[a] = {quo_q[a][QW-2:0], 1'b0};
      end
      if (pos_q[a]) begin
        num_first[a] = QW'((FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac_q[a]}) << 14;
      end else begin
        num_first[a] = QW'(frac_q[a]) << 14;
      end
    end
  end

  // Nearest crossing; strict compares send ties to the later axis: Y wins over X, and Z over both.
  assign x_before_y = vld_q[0] && (!vld_q[1] || tmax_q[0] < tmax_q[1]);
  assign x_before_z = vld_q[0] && (!vld_q[2] || tmax_q[0] < tmax_q[2]);
  assign y_before_z = vld_q[1] && (!vld_q[2] || tmax_q[1] < tmax_q[2]);
  assign none_valid = !vld_q[0] && !vld_q[1] && !vld_q[2];

  always_comb begin
    if (x_before_y) sel = x_before_z ? AXIS_X : AXIS_Z;
    else            sel = y_before_z ? AXIS_Y : AXIS_Z;
  end

  assign new_t  = tmax_q[sel];
  assign beyond = new_t > TW'(maxd_q);

  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.walk_last = none_valid || cmd_i.at_limit || beyond;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [47:0] oext;
        oext       = 48'(org[a]);
        cell_q[a] <= oext[FRAC_BITS +: CELL_BITS];
        frac_q[a] <= org[a][FRAC_BITS-1:0];
        pos_q[a]  <= !dir[a][15] && (dir[a] != 16'sd0);
        mag_q[a]  <= dir[a][15] ? 16'(-dir[a]) : 16'(dir[a]);
        vld_q[a]  <= (dir[a] != 16'sd0);
        rem_q[a]  <= '0;
        quo_q[a]  <= QW'(1) << (FRAC_BITS + 14);
      end
      maxd_q <= max_distance_i;
      t_q    <= '0;
      axis_q <= AXIS_NONE;
      neg_q  <= 1'b0;
    end else if (cmd_i.div_step) begin
      for (int a = 0; a < 3; a++) begin
        if (cmd_i.div_end && !cmd_i.phase_first) begin
          tdel_q[a] <= quo_n[a];
          rem_q[a]  <= '0;
          quo_q[a]  <= num_first[a];
        end else begin
          rem_q[a] <= rem_n[a];
          quo_q[a] <= quo_n[a];
          if (cmd_i.div_end) tmax_q[a] <= TW'(quo_n[a]);
        end
      end
    end else if (cmd_i.emit) begin
      cell_q[sel] <= pos_q[sel] ? cell_q[sel] + 1'b1 : cell_q[sel] - 1'b1;
      neg_q       <= pos_q[sel];
      axis_q      <= sel;
      t_q         <= new_t;
      tmax_q[sel] <= tmax_q[sel] + TW'(tdel_q[sel]);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int a = 0; a < 3; a++) begin
        logic [CELL_BITS+15:0] cw;
        cw          = {16'b0, cell_q[a]};
        ocell_q[a] <= cw[15:0];
      end
      oaxis_q  <= axis_q;
      oneg_q   <= neg_q;
      ot_q     <= (t_q > TW'(24'hFFFFFF)) ? 24'hFFFFFF : t_q[23:0];
      olast_q  <= status_o.walk_last;
      otrunc_q <= cmd_i.at_limit && !none_valid && !beyond;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_x_o        = ocell_q[0];
  assign cell_y_o        = ocell_q[1];
  assign cell_z_o        = ocell_q[2];
  assign face_axis_o     = oaxis_q;
  assign face_negative_o = oneg_q;
  assign entry_t_o       = ot_q;
  assign truncated_o     = otrunc_q;
  assign last_o          = olast_q;

endmodule

[rtl/core/voxel_ray_traversal_unit.sv]
// Top level of the voxel ray traversal unit (3D grid DDA walk).
// Each input item is one ray. Setup runs two restoring divisions on three
// lanes, one quotient bit per cycle: first the step size, then the first
// boundary crossing. The walk then sends one voxel per cycle while the
// output side takes items, up to MAX_STEPS voxels. The next ray is accepted
// in the cycle after the last voxel enters the output register. Each result
// item carries the voxel, its entry face and entry t; last marks the final
// voxel of a ray and truncated marks a walk cut off by the step limit while
// still inside the distance.
module voxel_ray_traversal_unit #(
  parameter int MAX_STEPS = 64,
  parameter int FRAC_BITS = 8,
  parameter int CELL_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] origin_x_i,
  input  logic signed [23:0] origin_y_i,
  input  logic signed [23:0] origin_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic [23:0]        max_distance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] cell_x_o,
  output logic signed [15:0] cell_y_o,
  output logic signed [15:0] cell_z_o,
  output logic [1:0]         face_axis_o,
  output logic               face_negative_o,
  output logic [23:0]        entry_t_o,
  output logic               truncated_o,
  output logic               last_o
);
  import vrt_pkg::*;

  vrt_cmd_t    cmd;
  vrt_status_t status;

  vrt_ctrl #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_STEPS(MAX_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  vrt_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .CELL_BITS(CELL_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .origin_z_i     (origin_z_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .max_distance_i (max_distance_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .cell_x_o       (cell_x_o),
    .cell_y_o       (cell_y_o),
    .cell_z_o       (cell_z_o),
    .face_axis_o    (face_axis_o),
    .face_negative_o(face_negative_o),
    .entry_t_o      (entry_t_o),
    .truncated_o    (truncated_o),
    .last_o         (last_o)
  );

endmodule

[test/tb_top.sv]
// Self-checking testbench for the voxel ray traversal unit.
`timescale 1ns / 1ps

// Holds the voxels each accepted ray is predicted to visit and checks results.
class voxel_walk_board;
  typedef struct packed {
    logic [15:0] cx, cy, cz;
    logic [1:0]  axis;
    logic        neg;
    logic [23:0] t;
    logic        trunc;
    logic        last;
  } voxel_t;

  voxel_t pending_voxels[$];
  int     mismatches;
  int     voxels_seen;
  int     rays_seen;

  function new();
    mismatches = 0;
    voxels_seen = 0;
    rays_seen = 0;
  endfunction

  // Walk the grid for one ray and queue every voxel that it enters.
  function void note_ray(logic [23:0] ox, logic [23:0] oy, logic [23:0] oz,
                         logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                         logic [23:0] maxd);
    logic [63:0] tmax[3], tdelta[3], vox[3], frac, mag, span, t;
    logic        ok[3], pos[3], ended, first_ok;
    logic [23:0] org[3];
    logic [15:0] dv[3];
    logic [1:0]  axis;
    logic        neg;
    int          n, a;
    voxel_t      v;
    org[0] = ox; org[1] = oy; org[2] = oz;
    dv[0] = dx; dv[1] = dy; dv[2] = dz;
    rays_seen++;
    for (a = 0; a < 3; a++) begin
      frac = {56'd0, org[a][7:0]};
      vox[a] = {48'd0, org[a][23:8]};
      if (dv[a][15]) begin
        pos[a] = 1'b0;
        mag = 64'h10000 - {48'd0, dv[a]};
      end else begin
        pos[a] = (dv[a] != 16'd0);
        mag = {48'd0, dv[a]};
      end
      ok[a] = (mag != 0);
      if (ok[a]) begin
        span = pos[a] ? (64'd256 - frac) : frac;
        tdelta[a] = (64'd256 * 64'd16384) / mag;
        tmax[a] = (span * 64'd16384) / mag;
      end else begin
        tdelta[a] = 0;
        tmax[a] = 0;
      end
    end
    t = 0;
    axis = vrt_pkg::AXIS_NONE;
    neg = 1'b0;
    n = 0;
    ended = 1'b0;
    while (t <= {40'd0, maxd} && n < 64) begin
      v.cx = vox[0][15:0];
      v.cy = vox[1][15:0];
      v.cz = vox[2][15:0];
      v.axis = axis;
      v.neg = neg;
      v.t = (t > 64'hFFFFFF) ? 24'hFFFFFF : t[23:0];
      v.trunc = 1'b0;
      v.last = 1'b0;
      pending_voxels.push_back(v);
      n++;
      if (!ok[0] && !ok[1] && !ok[2]) begin
        ended = 1'b1;
        break;
      end
      // Strict comparisons: on a tie Y wins over X, and Z over both.
      first_ok = ok[0] && (!ok[1] || tmax[0] < tmax[1]);
      if (first_ok)
        axis = (ok[0] && (!ok[2] || tmax[0] < tmax[2])) ? vrt_pkg::AXIS_X
                                                         : vrt_pkg::AXIS_Z;
      else
        axis = (ok[1] && (!ok[2] || tmax[1] < tmax[2])) ? vrt_pkg::AXIS_Y
                                                         : vrt_pkg::AXIS_Z;
      vox[axis] = pos[axis] ? vox[axis] + 1 : vox[axis] - 1;
      neg = pos[axis];
      t = tmax[axis];
      tmax[axis] += tdelta[axis];
    end
    v = pending_voxels.pop_back();
    v.last = 1'b1;
    v.trunc = (n == 64 && !ended && t <= {40'd0, maxd});
    pending_voxels.push_back(v);
  endfunction

  function void check_voxel(voxel_t got);
    voxel_t want;
    voxels_seen++;
    if (pending_voxels.size() == 0) begin
      $display("%0t: unexpected voxel, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_voxels.pop_front();
    if (got.cx !== want.cx)
      $display("%0t: cell_x expected %h actual %h", $time, want.cx, got.cx);
    if (got.cy !== want.cy)
      $display("%0t: cell_y expected %h actual %h", $time, want.cy, got.cy);
    if (got.cz !== want.cz)
      $display("%0t: cell_z expected %h actual %h", $time, want.cz, got.cz);
    if (got.axis !== want.axis)
      $display("%0t: face_axis expected %0d actual %0d", $time, want.axis, got.axis);
    if (got.neg !== want.neg)
      $display("%0t: face_negative expected %b actual %b", $time, want.neg, got.neg);
    if (got.t !== want.t)
      $display("%0t: entry_t expected %h actual %h", $time, want.t, got.t);
    if (got.trunc !== want.trunc)
      $display("%0t: truncated expected %b actual %b", $time, want.trunc, got.trunc);
    if (got.last !== want.last)
      $display("%0t: last expected %b actual %b", $time, want.last, got.last);
    if (got !== want) mismatches++;
  endfunction
endclass

module tb_top;
  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [23:0] origin_x_i, origin_y_i, origin_z_i;
  logic signed [15:0] dir_x_i, dir_y_i, dir_z_i;
  logic [23:0]        max_distance_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] cell_x_o, cell_y_o, cell_z_o;
  logic [1:0]         face_axis_o;
  logic               face_negative_o;
  logic [23:0]        entry_t_o;
  logic               truncated_o;
  logic               last_o;

  voxel_walk_board board;

  // Idle percentages per side, changed by the stimulus between phases.
  int  send_idle_pct;
  int  recv_idle_pct;
  // While set, the receiver stalls without a break so the block backs up.
  bit  hold_output;
  longint cycle_count;
  localparam longint CYCLE_LIMIT = 64'd4_000_000;

  voxel_ray_traversal_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .origin_x_i(origin_x_i), .origin_y_i(origin_y_i), .origin_z_i(origin_z_i),
    .dir_x_i(dir_x_i), .dir_y_i(dir_y_i), .dir_z_i(dir_z_i),
    .max_distance_i(max_distance_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .cell_x_o(cell_x_o), .cell_y_o(cell_y_o), .cell_z_o(cell_z_o),
    .face_axis_o(face_axis_o), .face_negative_o(face_negative_o),
    .entry_t_o(entry_t_o), .truncated_o(truncated_o), .last_o(last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Timeout guard: a hung block must not keep the run alive forever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver: random stall at the rising edge, checks each accepted item.
  // The sample is taken before the new stall value lands, so the handshake is
  // judged on the values that the edge itself saw.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_voxel({cell_x_o, cell_y_o, cell_z_o, face_axis_o,
                         face_negative_o, entry_t_o, truncated_o, last_o});
    out_stall_i <= hold_output || ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one ray and hold it until the block takes it. Valid drops only in
  // idle cycles, so back-to-back rays keep it high across the accepting edge.
  task automatic send_ray(logic [23:0] ox, logic [23:0] oy, logic [23:0] oz,
                          logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                          logic [23:0] maxd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ox; origin_y_i <= oy; origin_z_i <= oz;
    dir_x_i <= dx; dir_y_i <= dy; dir_z_i <= dz;
    max_distance_i <= maxd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_ray(ox, oy, oz, dx, dy, dz, maxd);
  endtask

  // A random component, mostly in the unit range, sometimes zero, a full unit or the out-of-range 16'h8000.
  function automatic logic [15:0] rand_dir();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'd0;
    if (k == 1) return ($urandom_range(1)) ? 16'd16384 : -16'sd16384;
    if (k == 2) return 16'h8000;
    return 16'($urandom_range(32768) - 16384);
  endfunction

  // Mostly short distances keep walks short; a few go the full step limit.
  task automatic send_random_ray();
    logic [23:0] maxd;
    logic [23:0] ox, oy, oz;
    int          k;
    k = $urandom_range(9);
    if (k < 6) maxd = 24'($urandom_range(4096));
    else if (k < 9) maxd = 24'($urandom_range(24'hFFFFFF));
    else maxd = 24'hFFFFFF;
    ox = 24'($urandom); oy = 24'($urandom); oz = 24'($urandom);
    send_ray(ox, oy, oz, rand_dir(), rand_dir(), rand_dir(), maxd);
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) send_random_ray();
  endtask

  int hold_cycles;

  initial begin
    board = new();
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_output = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    origin_x_i = '0; origin_y_i = '0; origin_z_i = '0;
    dir_x_i = '0; dir_y_i = '0; dir_z_i = '0;
    max_distance_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rays: all zero direction, single axes both ways, exact ties,
    // boundary origins with negative steps, the out-of-range component,
    // field extremes, zero distance and a walk cut off by the step limit.
    send_ray(24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0, 24'hFFFFFF);
    send_ray(24'd128, 24'd128, 24'd128, 16'd16384, 16'd0, 16'd0, 24'd2000);
    send_ray(24'd128, 24'd128, 24'd128, -16'sd16384, 16'd0, 16'd0, 24'd2000);
    send_ray(24'd128, 24'd128, 24'd128, 16'd0, 16'd16384, 16'd0, 24'd2000);
    send_ray(24'd128, 24'd128, 24'd128, 16'd0, 16'd0, -16'sd16384, 24'd2000);
    send_ray(24'd128, 24'd128, 24'd128, 16'd9459, 16'd9459, 16'd9459, 24'd3000);
    send_ray(24'd128, 24'd128, 24'd128, 16'd11585, 16'd11585, 16'd0, 24'd3000);
    send_ray(24'd0, 24'd256, 24'd512, -16'sd9459, -16'sd9459, -16'sd9459, 24'd3000);
    send_ray(24'd50, 24'd60, 24'd70, 16'h8000, 16'd0, 16'd0, 24'd3000);
    send_ray(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'd16384, -16'sd16384,
             16'd0, 24'd1000);
    send_ray(24'h800000, 24'h7FFFFF, 24'h800000, 16'h8000, 16'h8000,
             16'h8000, 24'hFFFFFF);
    send_ray(24'd77, 24'd99, 24'd11, 16'd5000, -16'sd7000, 16'd13000, 24'd0);
    send_ray(24'd1, 24'd2, 24'd3, 16'd1, 16'd16384, 16'd0, 24'hFFFFFF);
    send_ray(24'd200, 24'd10, 24'd255, 16'd8000, 16'd12000, -16'sd7000,
             24'hFFFFFF);
    send_ray(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, -16'sd1, -16'sd1, -16'sd1,
             24'hFFFFFF);
    send_ray(24'hAAAAAA, 24'h555555, 24'h123456, 16'h5555, 16'hAAAA, 16'h2AAA,
             24'h555555);

    // Long hold-off on the output while rays keep arriving.
    fork
      begin
        hold_output = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 600) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        hold_output = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_random_ray();
    join

    send_idle_pct = 21; recv_idle_pct = 54;
    run_phase(140);
    send_idle_pct = 54; recv_idle_pct = 21;
    run_phase(140);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_phase(140);
    in_valid_i <= 1'b0;

    while (board.pending_voxels.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d rays and %0d voxels under three idle patterns",
             board.rays_seen, board.voxels_seen);
    $display("including an output hold-off that backed up the input");
    if (board.mismatches == 0 && board.pending_voxels.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
